// ----- design/pdfi_pkg.sv -----
// -----------------------------------------------------------------------------
// pdfi_pkg
// Types and constants shared by the packet drop fault injector modules.
// -----------------------------------------------------------------------------
package pdfi_pkg;

   localparam int NODE_W   = 64;
   localparam int CNT_W    = 32;
   localparam int KIND_W   = 2;
   localparam int NKIND    = 4;
   localparam int PORTAL_W = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [NODE_W-1:0] NODE_ANY     = {NODE_W{1'b1}};
   localparam logic [CNT_W-1:0]  CNT_ALL      = {CNT_W{1'b1}};
   localparam logic [NKIND-1:0]  KIND_ALL     = 4'b1111;
   // put and get are the only kinds that carry a portal
   localparam logic [NKIND-1:0]  KIND_PUT_GET = 4'b0101;

   localparam int MODE_DROP_ALL_BIT = 0;
   localparam int MODE_RANDOM_BIT   = 1;

   localparam logic OP_JUDGE   = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_FILTER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_FILTER   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_FILTER  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_MASK     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PORTAL_MASK   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_RATE     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_INTERVAL = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE_FLAGS    = 3'd7;

   typedef struct packed {
      logic [NODE_W-1:0] source_filter;
      logic [NODE_W-1:0] dest_filter;
      logic [NODE_W-1:0] local_filter;
      logic [NKIND-1:0]  type_mask;
      logic [NODE_W-1:0] portal_mask;
      logic [CNT_W-1:0]  drop_rate;
      logic [CNT_W-1:0]  drop_interval;
      logic [1:0]        mode_flags;
   } cfg_type;

   // raw message word as captured from the request port
   typedef struct packed {
      logic                operation;
      logic [NODE_W-1:0]   source_node;
      logic [NODE_W-1:0]   dest_node;
      logic [NODE_W-1:0]   local_node;
      logic [KIND_W-1:0]   msg_kind;
      logic [PORTAL_W-1:0] portal_index;
      logic [CNT_W-1:0]    now_seconds;
      logic [CNT_W-1:0]    random_draw;
   } hdr_type;

   // state-independent part of the verdict
   typedef struct packed {
      logic              operation;
      logic              matched;
      logic [KIND_W-1:0] msg_kind;
      logic [CNT_W-1:0]  now_seconds;
      logic [CNT_W-1:0]  draw_rate;      // draw clamped below drop_rate
      logic [CNT_W-1:0]  draw_interval;  // draw clamped below drop_interval
      logic              random_drop;
      logic [CNT_W-1:0]  restart_next_second;
      logic [CNT_W-1:0]  restart_window;
   } judge_type;

   typedef struct packed {
      logic             drop;
      logic             matched;
      logic [CNT_W-1:0] match_total;
      logic [CNT_W-1:0] dropped_total;
   } result_type;

endpackage

// ----- design/pdfi_filter.sv -----
// -----------------------------------------------------------------------------
// pdfi_filter
// Node, kind and portal filters plus draw clamping for one message word.
// -----------------------------------------------------------------------------
module pdfi_filter
   import pdfi_pkg::*;
(
   input  cfg_type   cfg,
   input  hdr_type   msg,
   output judge_type judge
);

   function automatic logic node_ok(input logic [NODE_W-1:0] filt,
                                    input logic [NODE_W-1:0] node);
      logic net_eq;
      logic addr_any;
      net_eq   = filt[NODE_W-1:NODE_W/2] == node[NODE_W-1:NODE_W/2];
      addr_any = &filt[NODE_W/2-1:0];
      return (filt == node) || (filt == NODE_ANY) || (net_eq && addr_any);
   endfunction

   function automatic logic [CNT_W-1:0] clamp_draw(input logic [CNT_W-1:0] draw,
                                                   input logic [CNT_W-1:0] bound);
      logic [CNT_W-1:0] res;
      if (bound == '0) begin
         res = '0;
      end else if (draw >= bound) begin
         res = bound - CNT_W'(1);
      end else begin
         res = draw;
      end
      return res;
   endfunction

   logic [NKIND-1:0] kinds;
   logic             portal_ok;
   logic             nodes_ok;
   logic [CNT_W-1:0] draw_int;

   always_comb begin
      kinds = (cfg.type_mask == '0) ? KIND_ALL : cfg.type_mask;
      if (cfg.portal_mask != '0) begin
         kinds = kinds & KIND_PUT_GET;
      end
   end

   assign portal_ok = (cfg.portal_mask == '0) || cfg.portal_mask[msg.portal_index];
   assign nodes_ok  = node_ok(cfg.source_filter, msg.source_node)
                    && node_ok(cfg.dest_filter, msg.dest_node)
                    && node_ok(cfg.local_filter, msg.local_node);
   assign draw_int  = clamp_draw(msg.random_draw, cfg.drop_interval);

   always_comb begin
      judge.operation           = msg.operation;
      judge.matched             = (msg.operation == OP_JUDGE) && nodes_ok
                                  && kinds[msg.msg_kind] && portal_ok;
      judge.msg_kind            = msg.msg_kind;
      judge.now_seconds         = msg.now_seconds;
      judge.draw_rate           = clamp_draw(msg.random_draw, cfg.drop_rate);
      judge.draw_interval       = draw_int;
      // upper half of the interval drops
      judge.random_drop         = draw_int >= (cfg.drop_interval >> 1);
      judge.restart_next_second = msg.now_seconds + draw_int;
      judge.restart_window      = msg.now_seconds + cfg.drop_interval;
   end

endmodule

// ----- design/pdfi_rule.sv -----
// -----------------------------------------------------------------------------
// pdfi_rule
// Drop rule state: counters, rate phase and time windows; one word per cycle while advance is high.
// -----------------------------------------------------------------------------
module pdfi_rule
   import pdfi_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       advance,
   input  judge_type  judge,
   output result_type result
);

   logic [CNT_W-1:0] match_counter_ff,    match_counter_in;
   logic [CNT_W-1:0] rate_phase_ff,       rate_phase_in;
   logic [CNT_W-1:0] next_drop_index_ff,  next_drop_index_in;
   logic [CNT_W-1:0] next_drop_second_ff, next_drop_second_in;
   logic [CNT_W-1:0] window_base_ff,      window_base_in;
   logic [CNT_W-1:0] drop_counter_ff,     drop_counter_in;
   logic [CNT_W-1:0] per_kind_drops_ff [NKIND];
   logic [CNT_W-1:0] per_kind_drops_in [NKIND];

   logic             drop;
   logic [CNT_W-1:0] mc_inc;
   logic [CNT_W-1:0] phase_inc;
   logic [CNT_W-1:0] win_start;

   assign mc_inc    = match_counter_ff + CNT_W'(1);
   assign phase_inc = rate_phase_ff + CNT_W'(1);
   assign win_start = (judge.now_seconds > window_base_ff) ? judge.now_seconds
                                                            : window_base_ff;

   always_comb begin
      match_counter_in    = match_counter_ff;
      rate_phase_in       = rate_phase_ff;
      next_drop_index_in  = next_drop_index_ff;
      next_drop_second_in = next_drop_second_ff;
      window_base_in      = window_base_ff;
      drop_counter_in     = drop_counter_ff;
      per_kind_drops_in   = per_kind_drops_ff;
      drop                = 1'b0;

      if (judge.operation == OP_RESTART) begin
         match_counter_in = '0;
         rate_phase_in    = '0;
         drop_counter_in  = '0;
         for (int k = 0; k < NKIND; k++) begin
            per_kind_drops_in[k] = '0;
         end
         if (cfg.drop_rate != '0) begin
            next_drop_index_in = (cfg.drop_rate == CNT_W'(2)) ? '0 : judge.draw_rate;
         end else begin
            next_drop_second_in = judge.restart_next_second;
            window_base_in      = judge.restart_window;
         end
      end else if (judge.matched) begin
         priority if (cfg.mode_flags[MODE_DROP_ALL_BIT]) begin
            drop = 1'b1;
         end else if (cfg.mode_flags[MODE_RANDOM_BIT]) begin
            drop = judge.random_drop;
         end else if (cfg.drop_rate == '0) begin
            match_counter_in = mc_inc;
            drop = judge.now_seconds >= next_drop_second_ff;
            if (drop) begin
               next_drop_second_in = win_start + judge.draw_interval;
               window_base_in      = win_start + cfg.drop_interval;
            end
         end else begin
            drop             = match_counter_ff == next_drop_index_ff;
            match_counter_in = mc_inc;
            rate_phase_in    = phase_inc;
            // phase wraps when it reaches the rate: re-arm the next drop slot
            if (phase_inc >= cfg.drop_rate) begin
               rate_phase_in      = '0;
               next_drop_index_in = mc_inc + judge.draw_rate;
            end
         end
         if (drop) begin
            if (per_kind_drops_ff[judge.msg_kind] != CNT_ALL) begin
               per_kind_drops_in[judge.msg_kind] =
                  per_kind_drops_ff[judge.msg_kind] + CNT_W'(1);
            end
            if (drop_counter_ff != CNT_ALL) begin
               drop_counter_in = drop_counter_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_counter_ff    <= '0;
         rate_phase_ff       <= '0;
         next_drop_index_ff  <= '0;
         next_drop_second_ff <= '0;
         window_base_ff      <= '0;
         drop_counter_ff     <= '0;
         for (int k = 0; k < NKIND; k++) begin
            per_kind_drops_ff[k] <= '0;
         end
      end else if (advance) begin
         match_counter_ff    <= match_counter_in;
         rate_phase_ff       <= rate_phase_in;
         next_drop_index_ff  <= next_drop_index_in;
         next_drop_second_ff <= next_drop_second_in;
         window_base_ff      <= window_base_in;
         drop_counter_ff     <= drop_counter_in;
         per_kind_drops_ff   <= per_kind_drops_in;
      end
   end

   always_comb begin
      result.drop          = drop;
      result.matched       = judge.matched;
      result.match_total   = match_counter_in;
      result.dropped_total = drop_counter_in;
   end

endmodule

// ----- design/packet_drop_fault_injector_top.sv -----
// -----------------------------------------------------------------------------
// packet_drop_fault_injector_top
// One network fault rule: filters message headers and decides drops.
// -----------------------------------------------------------------------------
//  Channel | Ports                     | Direction | Word
//  --------+---------------------------+-----------+-------------------------
//  request | req_valid / req_stall     | in        | operation + header
//  result  | rsp_valid / rsp_stall     | out       | drop, matched, totals
//  config  | csr_write_en / csr_index  | in        | 64-bit csr_wdata
//
//  One word per cycle sustained while rsp_stall is low; an accepted word passes the
//  input, filter and result registers in order before it is on the rsp_ ports.
//  Rule state is read and updated in the single cycle a word moves into the
//  result register, so back-to-back words see each other's updates.
//  A stalled result holds; the two earlier stages keep filling, then
//  req_stall rises. Synchronous reset clears all control state and counters.
// -----------------------------------------------------------------------------
module packet_drop_fault_injector_top
   import pdfi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [NODE_W-1:0]    csr_wdata,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic [NODE_W-1:0]    req_source_node,
   input  logic [NODE_W-1:0]    req_dest_node,
   input  logic [NODE_W-1:0]    req_local_node,
   input  logic [KIND_W-1:0]    req_msg_kind,
   input  logic [PORTAL_W-1:0]  req_portal_index,
   input  logic [CNT_W-1:0]     req_now_seconds,
   input  logic [CNT_W-1:0]     req_random_draw,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_drop,
   output logic                 rsp_matched,
   output logic [CNT_W-1:0]     rsp_match_total,
   output logic [CNT_W-1:0]     rsp_dropped_total
);

   cfg_type    cfg_ff;
   hdr_type    msg_ff;
   judge_type  judge_ff, judge_in;
   result_type result_ff, result_in;

   logic valid_a_ff, valid_a_in;
   logic valid_b_ff, valid_b_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic out_move;
   logic b_free;
   logic b_move;
   logic a_free;
   logic a_move;
   logic accept;

   // ---- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_filter <= NODE_ANY;
         cfg_ff.dest_filter   <= NODE_ANY;
         cfg_ff.local_filter  <= NODE_ANY;
         cfg_ff.type_mask     <= '0;
         cfg_ff.portal_mask   <= '0;
         cfg_ff.drop_rate     <= '0;
         cfg_ff.drop_interval <= '0;
         cfg_ff.mode_flags    <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SOURCE_FILTER: cfg_ff.source_filter <= csr_wdata;
            CSR_DEST_FILTER:   cfg_ff.dest_filter   <= csr_wdata;
            CSR_LOCAL_FILTER:  cfg_ff.local_filter  <= csr_wdata;
            CSR_TYPE_MASK:     cfg_ff.type_mask     <= csr_wdata[NKIND-1:0];
            CSR_PORTAL_MASK:   cfg_ff.portal_mask   <= csr_wdata;
            CSR_DROP_RATE:     cfg_ff.drop_rate     <= csr_wdata[CNT_W-1:0];
            CSR_DROP_INTERVAL: cfg_ff.drop_interval <= csr_wdata[CNT_W-1:0];
            CSR_MODE_FLAGS:    cfg_ff.mode_flags    <= csr_wdata[1:0];
         endcase
      end
   end

   // ---- pipeline flow control
   assign out_move  = !rsp_valid_ff || !rsp_stall;
   assign b_move    = valid_b_ff && out_move;
   assign b_free    = !valid_b_ff || out_move;
   assign a_move    = valid_a_ff && b_free;
   assign a_free    = !valid_a_ff || b_free;
   assign req_stall = !a_free;
   assign accept    = req_valid && a_free;

   assign valid_a_in   = accept || (valid_a_ff && !b_free);
   assign valid_b_in   = a_move || (valid_b_ff && !out_move);
   assign rsp_valid_in = b_move || (rsp_valid_ff && !out_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= 1'b0;
         valid_b_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_a_ff   <= valid_a_in;
         valid_b_ff   <= valid_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---- input register
   always_ff @(posedge clock) begin
      if (accept) begin
         msg_ff.operation    <= req_operation;
         msg_ff.source_node  <= req_source_node;
         msg_ff.dest_node    <= req_dest_node;
         msg_ff.local_node   <= req_local_node;
         msg_ff.msg_kind     <= req_msg_kind;
         msg_ff.portal_index <= req_portal_index;
         msg_ff.now_seconds  <= req_now_seconds;
         msg_ff.random_draw  <= req_random_draw;
      end
   end

   pdfi_filter u_filter (
      .cfg   (cfg_ff),
      .msg   (msg_ff),
      .judge (judge_in)
   );

   // ---- filter register
   always_ff @(posedge clock) begin
      if (a_move) begin
         judge_ff <= judge_in;
      end
   end

   pdfi_rule u_rule (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .advance (b_move),
      .judge   (judge_ff),
      .result  (result_in)
   );

   // ---- result register
   always_ff @(posedge clock) begin
      if (b_move) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drop          = result_ff.drop;
   assign rsp_matched       = result_ff.matched;
   assign rsp_match_total   = result_ff.match_total;
   assign rsp_dropped_total = result_ff.dropped_total;

endmodule

// ----- tb/tb_packet_drop_fault_injector_top.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_packet_drop_fault_injector_top
// Self-checking bench for the packet drop fault injector. A clocked driver
// feeds queued header words in random bursts while the receiver stalls on its
// own pattern. Every accepted word is judged by a local model of the drop rule
// and the expected verdict is compared with each result word in order. Rule
// registers are rewritten only while the block is idle between phases.
// -----------------------------------------------------------------------------
module tb_packet_drop_fault_injector_top;
   import pdfi_pkg::*;

   localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GET   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REPLY = 2'd3;

   localparam logic [1:0] MODE_RATE_TIME = 2'd0;
   localparam logic [1:0] MODE_DROP_ALL  = 2'd1;
   localparam logic [1:0] MODE_RANDOM    = 2'd2;
   localparam logic [1:0] MODE_BOTH      = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [NODE_W-1:0]    csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   hdr_type              req_word = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_drop;
   logic                 rsp_matched;
   logic [CNT_W-1:0]     rsp_match_total;
   logic [CNT_W-1:0]     rsp_dropped_total;
   result_type           rsp_seen;

   assign rsp_seen = {rsp_drop, rsp_matched, rsp_match_total, rsp_dropped_total};

   packet_drop_fault_injector_top u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_word.operation),
      .req_source_node   (req_word.source_node),
      .req_dest_node     (req_word.dest_node),
      .req_local_node    (req_word.local_node),
      .req_msg_kind      (req_word.msg_kind),
      .req_portal_index  (req_word.portal_index),
      .req_now_seconds   (req_word.now_seconds),
      .req_random_draw   (req_word.random_draw),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drop          (rsp_drop),
      .rsp_matched       (rsp_matched),
      .rsp_match_total   (rsp_match_total),
      .rsp_dropped_total (rsp_dropped_total)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Drop rule model
   // ---------------------------------------------------------------------------
   cfg_type          rule_cfg;
   logic [CNT_W-1:0] match_count, rate_phase, next_drop_idx;
   logic [CNT_W-1:0] next_drop_sec, window_end, drop_count;
   logic [CNT_W-1:0] kind_drops [NKIND];

   function automatic logic node_hit(input logic [NODE_W-1:0] filt, node);
      if (filt == node || filt == NODE_ANY) return 1'b1;
      return (filt[63:32] == node[63:32]) && (filt[31:0] == CNT_ALL);
   endfunction

   function automatic logic [CNT_W-1:0] clamp_below(input logic [CNT_W-1:0] v, bound);
      if (bound == '0) return '0;
      return (v >= bound) ? bound - 1 : v;
   endfunction

   function automatic logic [CNT_W-1:0] sat_add1(input logic [CNT_W-1:0] v);
      return (v == CNT_ALL) ? v : v + 1;
   endfunction

   function automatic result_type judge_message(input hdr_type m);
      logic [NKIND-1:0] kinds;
      logic             hit;
      logic             drop;
      result_type       r;
      hit  = 1'b0;
      drop = 1'b0;
      if (m.operation == OP_RESTART) begin
         match_count = '0;
         rate_phase  = '0;
         drop_count  = '0;
         foreach (kind_drops[i]) kind_drops[i] = '0;
         if (rule_cfg.drop_rate != '0) begin
            next_drop_idx = (rule_cfg.drop_rate == 2) ? '0 :
                            clamp_below(m.random_draw, rule_cfg.drop_rate);
         end else begin
            next_drop_sec = m.now_seconds +
                            clamp_below(m.random_draw, rule_cfg.drop_interval);
            window_end    = m.now_seconds + rule_cfg.drop_interval;
         end
      end else begin
         kinds = (rule_cfg.type_mask == '0) ? KIND_ALL : rule_cfg.type_mask;
         if (rule_cfg.portal_mask != '0) kinds &= KIND_PUT_GET;
         hit = node_hit(rule_cfg.source_filter, m.source_node) &&
               node_hit(rule_cfg.dest_filter, m.dest_node) &&
               node_hit(rule_cfg.local_filter, m.local_node) &&
               kinds[m.msg_kind] &&
               (rule_cfg.portal_mask == '0 || rule_cfg.portal_mask[m.portal_index]);
         if (hit) begin
            if (rule_cfg.mode_flags[MODE_DROP_ALL_BIT]) begin
               drop = 1'b1;
            end else if (rule_cfg.mode_flags[MODE_RANDOM_BIT]) begin
               drop = clamp_below(m.random_draw, rule_cfg.drop_interval) >=
                      (rule_cfg.drop_interval >> 1);
            end else if (rule_cfg.drop_rate == '0) begin
               // time windows: at most one drop per window
               match_count = match_count + 1;
               drop = m.now_seconds >= next_drop_sec;
               if (drop) begin
                  if (m.now_seconds > window_end) window_end = m.now_seconds;
                  next_drop_sec = window_end +
                                  clamp_below(m.random_draw, rule_cfg.drop_interval);
                  window_end = window_end + rule_cfg.drop_interval;
               end
            end else begin
               drop = (match_count == next_drop_idx);
               match_count = match_count + 1;
               rate_phase  = rate_phase + 1;
               if (rate_phase >= rule_cfg.drop_rate) begin
                  rate_phase    = '0;
                  next_drop_idx = match_count +
                                  clamp_below(m.random_draw, rule_cfg.drop_rate);
               end
            end
            if (drop) begin
               kind_drops[m.msg_kind] = sat_add1(kind_drops[m.msg_kind]);
               drop_count = sat_add1(drop_count);
            end
         end
      end
      r.drop          = drop;
      r.matched       = hit;
      r.match_total   = match_count;
      r.dropped_total = drop_count;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver, receiver and checker
   // ---------------------------------------------------------------------------
   hdr_type    pending_words [$];
   result_type verdict_q [$];
   int         fail_count = 0;
   logic       req_taken = 1'b0;
   int         burst_left = 0;
   int         gap_left = 0;
   int         hold_left = 0;
   int         hold_timer = 200;
   int         stretch_left = 0;
   int         stall_pct = 0;
   logic [CNT_W-1:0] wall_sec = '0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_word  <= pending_words.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 30);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall density changes per stretch, plus a periodic long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (hold_timer == 0) begin
            hold_left  = $urandom_range(30, 60);
            hold_timer = $urandom_range(150, 400);
         end else begin
            hold_timer--;
         end
         if (stretch_left == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_pct = 0;
               1:       stall_pct = 10;
               2:       stall_pct = 50;
               default: stall_pct = 80;
            endcase
            stretch_left = $urandom_range(5, 40);
         end else begin
            stretch_left--;
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   task automatic note_failure(input string what, input result_type want);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t %s: expected drop=%0b matched=%0b match_total=%0d dropped_total=%0d",
                  $time, what, want.drop, want.matched, want.match_total,
                  want.dropped_total);
         $display("   got drop=%0b matched=%0b match_total=%0d dropped_total=%0d",
                  rsp_seen.drop, rsp_seen.matched, rsp_seen.match_total,
                  rsp_seen.dropped_total);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) note_failure("unexpected result", '0);
            else if (rsp_seen !== verdict_q[0]) note_failure("mismatch", verdict_q[0]);
            if (verdict_q.size() != 0) void'(verdict_q.pop_front());
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) verdict_q.push_back(judge_message(req_word));
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [NODE_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_SOURCE_FILTER: rule_cfg.source_filter = data;
         CSR_DEST_FILTER:   rule_cfg.dest_filter   = data;
         CSR_LOCAL_FILTER:  rule_cfg.local_filter  = data;
         CSR_TYPE_MASK:     rule_cfg.type_mask     = data[NKIND-1:0];
         CSR_PORTAL_MASK:   rule_cfg.portal_mask   = data;
         CSR_DROP_RATE:     rule_cfg.drop_rate     = data[CNT_W-1:0];
         CSR_DROP_INTERVAL: rule_cfg.drop_interval = data[CNT_W-1:0];
         CSR_MODE_FLAGS:    rule_cfg.mode_flags    = data[1:0];
         default: ;
      endcase
   endtask

   function automatic void queue_word(input logic op, input logic [NODE_W-1:0] src, dst, loc,
                                      input logic [KIND_W-1:0] kind,
                                      input logic [PORTAL_W-1:0] portal,
                                      input logic [CNT_W-1:0] now, draw);
      hdr_type w;
      w.operation    = op;
      w.source_node  = src;
      w.dest_node    = dst;
      w.local_node   = loc;
      w.msg_kind     = kind;
      w.portal_index = portal;
      w.now_seconds  = now;
      w.random_draw  = draw;
      pending_words.push_back(w);
   endfunction

   // sender stays quiet until every verdict is back, then the task waits out its extra argument
   task automatic drain_words(input int extra);
      while (pending_words.size() != 0 || verdict_q.size() != 0 || req_valid)
         @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_half();
      case ($urandom_range(0, 3))
         0:       return 32'h0;
         1:       return 32'h1;
         2:       return CNT_ALL;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [NODE_W-1:0] near_node(input logic [NODE_W-1:0] filt);
      case ($urandom_range(0, 3))
         0:       return filt;
         1:       return {filt[63:32], pick_half()};
         2:       return {$urandom, $urandom};
         default: return {pick_half(), filt[31:0]};
      endcase
   endfunction

   // upper bits beyond a narrow register, sometimes set
   function automatic logic [NODE_W-1:0] junk_bits();
      return ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
   endfunction

   task automatic write_random_rule();
      logic [NODE_W-1:0] filt [3];
      logic [NODE_W-1:0] pmask;
      logic [CNT_W-1:0]  rate, ivl;
      logic [NKIND-1:0]  tmask;
      logic [1:0]        mode;
      foreach (filt[i]) begin
         case ($urandom_range(0, 3))
            0:       filt[i] = NODE_ANY;
            1:       filt[i] = {pick_half(), CNT_ALL};
            2:       filt[i] = {pick_half(), pick_half()};
            default: filt[i] = {$urandom, $urandom};
         endcase
      end
      case ($urandom_range(0, 4))
         0, 1:    pmask = '0;
         2:       pmask = {$urandom, $urandom};
         3:       pmask = 64'h1 << $urandom_range(0, 63);
         default: pmask = NODE_ANY;
      endcase
      tmask = ($urandom_range(0, 2) == 0) ? '0 : NKIND'($urandom_range(0, 15));
      case ($urandom_range(0, 7))
         0, 1, 2, 3: rate = '0;
         4:          rate = 1;
         5:          rate = 2;
         6:          rate = $urandom_range(3, 12);
         default:    rate = ($urandom_range(0, 1) == 0) ? CNT_ALL : $urandom;
      endcase
      case ($urandom_range(0, 6))
         0:       ivl = '0;
         5:       ivl = CNT_ALL;
         6:       ivl = $urandom;
         default: ivl = $urandom_range(1, 20);
      endcase
      mode = ($urandom_range(0, 1) == 0) ? MODE_RATE_TIME : 2'($urandom_range(1, 3));
      write_csr(CSR_SOURCE_FILTER, filt[0]);
      write_csr(CSR_DEST_FILTER, filt[1]);
      write_csr(CSR_LOCAL_FILTER, filt[2]);
      write_csr(CSR_TYPE_MASK, (junk_bits() & ~64'hF) | NODE_W'(tmask));
      write_csr(CSR_PORTAL_MASK, pmask);
      write_csr(CSR_DROP_RATE, {CNT_W'(junk_bits() >> 32), rate});
      write_csr(CSR_DROP_INTERVAL, {CNT_W'(junk_bits() >> 32), ivl});
      write_csr(CSR_MODE_FLAGS, (junk_bits() & ~64'h3) | NODE_W'(mode));
   endtask

   task automatic queue_random_phase(input int count);
      logic [CNT_W-1:0]    bound, draw;
      logic [PORTAL_W-1:0] portal;
      logic                op;
      bound = (rule_cfg.drop_rate != '0) ? rule_cfg.drop_rate : rule_cfg.drop_interval;
      if ($urandom_range(0, 3) == 0) wall_sec = CNT_ALL - $urandom_range(0, 200);
      // most phases start from a fresh restart, others keep the old counters
      if ($urandom_range(0, 3) != 0)
         queue_word(OP_RESTART, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, KIND_W'($urandom_range(0, 3)),
                    PORTAL_W'($urandom_range(0, 63)), wall_sec, $urandom);
      repeat (count) begin
         if ($urandom_range(0, 19) == 0) wall_sec = $urandom;
         else wall_sec = wall_sec + $urandom_range(0, 3);
         case ($urandom_range(0, 3))
            0:       draw = $urandom;
            1:       draw = CNT_ALL;
            default: draw = (bound < 1000) ? $urandom_range(0, bound + 1) : $urandom;
         endcase
         portal = PORTAL_W'($urandom_range(0, 63));
         for (int t = 0; t < 8 && rule_cfg.portal_mask != '0 &&
              !rule_cfg.portal_mask[portal]; t++)
            portal = PORTAL_W'($urandom_range(0, 63));
         op = ($urandom_range(0, 19) == 0) ? OP_RESTART : OP_JUDGE;
         queue_word(op, near_node(rule_cfg.source_filter),
                    near_node(rule_cfg.dest_filter), near_node(rule_cfg.local_filter),
                    KIND_W'($urandom_range(0, 3)), portal, wall_sec, draw);
      end
   endtask

   initial begin
      logic [NODE_W-1:0] dst_id;
      dst_id = 64'hAAAA_5555_0F0F_F0F0;
      rule_cfg = '{source_filter: NODE_ANY, dest_filter: NODE_ANY, local_filter: NODE_ANY,
                   type_mask: '0, portal_mask: '0, drop_rate: '0, drop_interval: '0,
                   mode_flags: MODE_RATE_TIME};
      match_count   = '0;
      rate_phase    = '0;
      next_drop_idx = '0;
      next_drop_sec = '0;
      window_end    = '0;
      drop_count    = '0;
      foreach (kind_drops[i]) kind_drops[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset rule: any node, time mode with a zero-length window
      queue_word(OP_JUDGE, '0, '0, '0, KIND_PUT, '0, '0, '0);
      queue_word(OP_JUDGE, NODE_ANY, NODE_ANY, NODE_ANY, KIND_REPLY, 6'd63, CNT_ALL, CNT_ALL);
      queue_word(OP_RESTART, '0, '0, '0, KIND_PUT, '0, 32'd100, 32'd5);
      queue_word(OP_JUDGE, '0, '0, '0, KIND_GET, '0, 32'd99, '0);
      queue_word(OP_JUDGE, '0, '0, '0, KIND_ACK, '0, 32'd100, '0);
      drain_words(5);

      // net wildcard on source, exact destination, acks only, drop all
      write_csr(CSR_SOURCE_FILTER, {32'h0000_1234, CNT_ALL});
      write_csr(CSR_DEST_FILTER, dst_id);
      write_csr(CSR_TYPE_MASK, 64'h2);
      write_csr(CSR_MODE_FLAGS, NODE_W'(MODE_DROP_ALL));
      queue_word(OP_JUDGE, {32'h0000_1234, 32'h7}, dst_id, 64'h5, KIND_ACK, '0, '0, '0);
      queue_word(OP_JUDGE, {32'h0000_1235, 32'h7}, dst_id, 64'h5, KIND_ACK, '0, '0, '0);
      queue_word(OP_JUDGE, {32'h0000_1234, 32'h7}, dst_id, 64'h5, KIND_PUT, '0, '0, '0);
      queue_word(OP_JUDGE, {32'h0000_1234, 32'h7}, dst_id ^ 64'h1, 64'h5, KIND_ACK, '0, '0, '0);
      drain_words(5);

      // portal filter with a type mask that leaves neither put nor get
      write_csr(CSR_SOURCE_FILTER, NODE_ANY);
      write_csr(CSR_DEST_FILTER, NODE_ANY);
      write_csr(CSR_TYPE_MASK, 64'hA);
      write_csr(CSR_PORTAL_MASK, 64'h20);
      queue_word(OP_JUDGE, '0, '0, '0, KIND_PUT, 6'd5, '0, '0);
      queue_word(OP_JUDGE, '0, '0, '0, KIND_ACK, 6'd5, '0, '0);
      drain_words(5);

      // both mode bits act as drop all; portal filter keeps put and get
      write_csr(CSR_TYPE_MASK, '0);
      write_csr(CSR_MODE_FLAGS, NODE_W'(MODE_BOTH));
      queue_word(OP_JUDGE, '0, '0, '0, KIND_PUT, 6'd5, '0, '0);
      queue_word(OP_JUDGE, '0, '0, '0, KIND_GET, 6'd6, '0, '0);
      queue_word(OP_JUDGE, '0, '0, '0, KIND_ACK, 6'd5, '0, '0);
      drain_words(5);

      // random mode: zero interval drops every match, then upper half of 10
      write_csr(CSR_PORTAL_MASK, '0);
      write_csr(CSR_MODE_FLAGS, NODE_W'(MODE_RANDOM));
      queue_word(OP_JUDGE, '0, '0, '0, KIND_GET, '0, '0, 32'd7);
      drain_words(5);
      write_csr(CSR_DROP_INTERVAL, 64'd10);
      queue_word(OP_JUDGE, '0, '0, '0, KIND_PUT, '0, '0, 32'd4);
      queue_word(OP_JUDGE, '0, '0, '0, KIND_PUT, '0, '0, 32'd5);
      queue_word(OP_JUDGE, '0, '0, '0, KIND_PUT, '0, '0, CNT_ALL);
      drain_words(5);

      // rate of two re-arms at index zero
      write_csr(CSR_MODE_FLAGS, NODE_W'(MODE_RATE_TIME));
      write_csr(CSR_DROP_RATE, 64'd2);
      queue_word(OP_RESTART, '0, '0, '0, KIND_PUT, '0, '0, 32'd1);
      queue_word(OP_JUDGE, '0, '0, '0, KIND_PUT, '0, '0, 32'd1);
      queue_word(OP_JUDGE, '0, '0, '0, KIND_PUT, '0, '0, 32'd1);
      queue_word(OP_JUDGE, '0, '0, '0, KIND_PUT, '0, '0, 32'd1);
      drain_words(5);

      // lowering the rate under the current phase wraps it
      write_csr(CSR_DROP_RATE, 64'd5);
      queue_word(OP_RESTART, '0, '0, '0, KIND_PUT, '0, '0, 32'd3);
      repeat (3) queue_word(OP_JUDGE, '0, '0, '0, KIND_GET, '0, '0, 32'd1);
      drain_words(5);
      write_csr(CSR_DROP_RATE, 64'd2);
      queue_word(OP_JUDGE, '0, '0, '0, KIND_GET, '0, '0, 32'd1);
      queue_word(OP_JUDGE, '0, '0, '0, KIND_GET, '0, '0, 32'd0);
      drain_words(5);

      repeat (12) begin
         write_random_rule();
         queue_random_phase(100);
         drain_words(5);
      end
      drain_words(10);

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
